### sv/replay_id_filter_core_defines.svh
// Assertion macros for the replay ID filter RTL; only the filter core includes them.
// No dependencies; files that assert include this header by name.
`ifndef REPLAY_ID_FILTER_CORE_DEFINES_SVH
`define REPLAY_ID_FILTER_CORE_DEFINES_SVH

// Checked on every rising edge of clk outside of reset.
`define RIF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define RIF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rif_pkg.sv
// Shared types and constants for the replay ID filter.
// No dependencies; imported by the filter core and its history RAM.
`default_nettype none

package rif_pkg;

  localparam int unsigned ID_W = 32;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef logic [ID_W-1:0] rif_id_t;

endpackage

`default_nettype wire

### sv/rif_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Imports rif_pkg but uses nothing from it; the default word width is a literal.
`default_nettype none

module rif_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);
  import rif_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/replay_id_filter_core.sv
// Replay ID filter core: sequencer that scans and updates the ID history RAM.
// Depends on rif_pkg, rif_ram and replay_id_filter_core_defines.svh.
//
// Usage:
// The input stream carries one 32-bit message ID per transaction on in_tdata.
// For every accepted ID the block returns exactly one transaction on out_tdata,
// whose bit 0 is 1 when the ID was absent from the history (it is now stored)
// and 0 when the ID is a replay. The history holds the HISTORY_DEPTH most recent
// distinct IDs in a RAM; when full, the oldest entry is overwritten.
// One item is processed at a time. The scan reads one RAM entry per cycle, from
// entry 0 up to the last stored one, and stops at the first match (a replay). A
// new ID goes on to the RAM write after the scan, or straight after acceptance
// when the history is empty. in_tready is high again at the edge that loads the
// result into the output register.
// The output register holds a result while out_tready is low; the block then
// still accepts and scans the next ID and waits only to hand over its result.
// A synchronous active-low reset empties the history at once; no clearing pass
// is needed because the fill count marks which RAM entries are valid.
`default_nettype none
`include "replay_id_filter_core_defines.svh"

module replay_id_filter_core #(
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [rif_pkg::ID_W-1:0]          in_tdata,   // [31:0] message_id
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [rif_pkg::OUT_TDATA_W-1:0]   out_tdata   // [0] is_new, [7:1] zero
);
  import rif_pkg::*;

  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  rif_id_t       id_r, id_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          res_r, res_nxt;
  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_new_r, out_new_nxt;

  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  rif_id_t       ram_rdata;
  logic          in_fire;
  logic          scan_last;
  logic          match;

  rif_ram #(
    .WIDTH (ID_W),
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_history (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (oldest_r),
    .wr_data (id_r),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_new_r};

  assign match     = (ram_rdata == id_r);
  assign scan_last = ((CW'(cnt_r) + CW'(1)) == fill_r);

  always_comb begin
    state_nxt     = state_r;
    id_nxt        = id_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    oldest_nxt    = oldest_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    out_new_nxt   = out_new_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          id_nxt    = in_tdata;
          cnt_nxt   = '0;
          ram_re    = 1'b1;
          ram_raddr = '0;
          if (fill_r == '0) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (scan_last) begin
          state_nxt = S_WRITE;
        end else begin
          cnt_nxt   = AW'(cnt_r + AW'(1));
          ram_re    = 1'b1;
          ram_raddr = AW'(cnt_r + AW'(1));
        end
      end
      S_WRITE: begin
        ram_we  = 1'b1;
        res_nxt = 1'b1;
        if (oldest_r == AW'(HISTORY_DEPTH - 1)) begin
          oldest_nxt = '0;
        end else begin
          oldest_nxt = AW'(oldest_r + AW'(1));
        end
        if (fill_r != CW'(HISTORY_DEPTH)) begin
          fill_nxt = CW'(fill_r + CW'(1));
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_new_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    cnt_r     <= cnt_nxt;
    res_r     <= res_nxt;
    out_new_r <= out_new_nxt;
  end

  `RIF_ASSERT(a_fill_range, fill_r <= CW'(HISTORY_DEPTH), "fill count exceeds history depth")
  `RIF_ASSERT(a_fill_tracks_slot, (fill_r != CW'(HISTORY_DEPTH)) |-> (CW'(oldest_r) == fill_r),
    "write slot does not follow fill count while history fills")
  `RIF_ASSERT(a_scan_in_range, (state_r == S_SCAN) |-> (CW'(cnt_r) < fill_r),
    "scan reads beyond the valid entries")
  `RIF_ASSERT(a_write_grows, ram_we |=> (fill_r != '0),
    "history empty after a write")
  `RIF_ASSERT(a_no_rw_overlap, ram_we |-> !ram_re,
    "history read and write in the same cycle")

endmodule

`default_nettype wire

### sim/rif_history_checker.sv
`timescale 1ns / 1ps
// Watches both streams of the replay ID filter, predicts the new/replay flag per ID
// and compares it with every result transaction, whose padding bits it also checks. Depends on rif_pkg.
module rif_history_checker #(
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [rif_pkg::ID_W-1:0]          in_tdata,   // [31:0] message_id
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [rif_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [0] is_new, [7:1] zero
  output int unsigned                       pending_results,
  output int unsigned                       mismatch_count
);
  import rif_pkg::*;

  rif_id_t     seen_ids   [HISTORY_DEPTH];
  bit          seen_valid [HISTORY_DEPTH];
  int unsigned next_slot;
  bit          expected_is_new [$];

  initial begin
    pending_results = 0;
    mismatch_count  = 0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Looks the ID up in the history and stores it if absent.
  task automatic lookup_and_store(input rif_id_t id, output bit fresh);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (seen_valid[i] && seen_ids[i] == id) begin
        hit = 1'b1;
      end
    end
    fresh = !hit;
    if (fresh) begin
      seen_ids[next_slot]   = id;
      seen_valid[next_slot] = 1'b1;
      next_slot = (next_slot == HISTORY_DEPTH - 1) ? 0 : next_slot + 1;
    end
  endtask

  always @(posedge clk) begin
    bit fresh;
    bit want;
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        seen_valid[i] = 1'b0;
      end
      next_slot = 0;
      expected_is_new.delete();
      pending_results <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        lookup_and_store(in_tdata, fresh);
        expected_is_new.push_back(fresh);
      end
      if (out_tvalid && out_tready) begin
        if (expected_is_new.size() == 0) begin
          report_mismatch($sformatf("result 0x%02h with no ID waiting", out_tdata));
        end else begin
          want = expected_is_new.pop_front();
          if (out_tdata[0] !== want) begin
            report_mismatch($sformatf("is_new %b, expected %b", out_tdata[0], want));
          end
          if (out_tdata[OUT_TDATA_W-1:1] !== '0) begin
            report_mismatch($sformatf("padding bits 0x%02h not zero", out_tdata));
          end
        end
      end
      pending_results <= expected_is_new.size();
    end
  end

endmodule

### sim/tb_replay_id_filter_core.sv
`timescale 1ns / 1ps
// Stimulus and verdict for replay_id_filter_core: directed and random message IDs
// under varying stream stalls. Depends on rif_pkg, the core and rif_history_checker.
module tb_replay_id_filter_core;
  import rif_pkg::*;

  localparam int unsigned HISTORY_DEPTH = 32;
  localparam int unsigned PHASE_ITEMS   = 330;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RECENT_MAX    = 48;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [ID_W-1:0]        in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int unsigned pending_results;
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned holds_asked;
  rif_id_t     recent_ids [$];

  replay_id_filter_core #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  rif_history_checker #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .pending_results(pending_results),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls, plus long hold-offs on request.
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && holds_done < holds_asked) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_id(input rif_id_t id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= id;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    recent_ids.push_front(id);
    if (recent_ids.size() > RECENT_MAX) begin
      void'(recent_ids.pop_back());
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Mostly fresh IDs and repeats of recent ones, some still stored and some
  // already evicted, with bit-pattern extremes mixed in.
  function automatic rif_id_t pick_id();
    int unsigned roll;
    int unsigned bit_pos;
    roll    = $urandom_range(99);
    bit_pos = $urandom_range(ID_W - 1);
    if (roll < 45 || recent_ids.size() == 0) begin
      return $urandom;
    end else if (roll < 90) begin
      return recent_ids[$urandom_range(recent_ids.size() - 1)];
    end else if (roll < 93) begin
      return '0;
    end else if (roll < 96) begin
      return '1;
    end else if (roll < 98) begin
      return rif_id_t'(1) << bit_pos;
    end
    return ~(rif_id_t'(1) << bit_pos);
  endfunction

  initial begin
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    holds_asked   <= 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_id(32'h0000_0000);
    send_id(32'h0000_0000);
    send_id(32'hFFFF_FFFF);
    send_id(32'hFFFF_FFFF);
    send_id(32'h0000_0001);
    send_id(32'h8000_0000);
    send_id(32'hAAAA_AAAA);
    send_id(32'h5555_5555);
    send_id(32'h0000_0000);
    send_id(32'h7FFF_FFFF);
    send_id(32'hFFFF_FFFE);
    send_id(32'h5555_5555);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          holds_asked <= holds_asked + 1;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_id(pick_id());
      end
      wait_drained();
    end

    repeat (HISTORY_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
